FILE: sv/packed_text_unpacker_unit_defines.svh
// assertion macros used by the rtl
`ifndef PACKED_TEXT_UNPACKER_UNIT_DEFINES_SVH
`define PACKED_TEXT_UNPACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PTU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PTU_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PTU_ASSERT(lbl, prop)
`define PTU_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: sv/ptu_pkg.sv
`default_nettype none

package ptu_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned ResCntW   = 2;
  localparam int unsigned FifoDepth = 4;

  localparam logic [DataW-1:0]  HdrIntro   = 8'h01;
  localparam logic [DataW-1:0]  HdrUncomp  = 8'h02;
  localparam logic [DataW-1:0]  HdrStart   = 8'h05;
  localparam logic [CodeW-1:0]  CodeEnd    = 7'h03;
  localparam logic [CodeW-1:0]  CodeSpace  = 7'h20;
  localparam logic [CodeW-1:0]  CodeMaxPr  = 7'h7E;
  localparam logic [PhaseW-1:0] PhaseFirst = 3'd1;
  localparam logic [PhaseW-1:0] PhaseWrap  = 3'd7;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_END     = 3'd1,
    KIND_INTRO   = 3'd2,
    KIND_UNCOMP  = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CodeW-1:0] char_code;
    logic             last;
  } res_t;

  typedef struct packed {
    logic              unpacking;
    logic [DataW-1:0]  prev_byte;
    logic [PhaseW-1:0] bit_phase;
  } st_t;

  typedef struct packed {
    logic [ResCntW-1:0]       n;
    res_t [MaxRes-1:0]        res;
  } dec_t;

  typedef struct packed {
    logic valid;
    logic room;
  } fifo_st_t;

  function automatic logic [CodeW-1:0] fix_code(input logic [CodeW-1:0] c);
    return (c < CodeSpace || c > CodeMaxPr) ? CodeSpace : c;
  endfunction

  function automatic res_t mk_char(input logic [CodeW-1:0] c);
    res_t r;
    r.kind      = KIND_CHAR;
    r.char_code = fix_code(c);
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_rec_end(input kind_e k);
    res_t r;
    r.kind      = k;
    r.char_code = '0;
    r.last      = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ptu_in_if.sv
`default_nettype none

interface ptu_in_if import ptu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/ptu_out_if.sv
`default_nettype none

interface ptu_out_if import ptu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [CodeW-1:0] char_code;
  logic             last;

  modport source (output valid, output kind, output char_code, output last, input ready);
  modport sink (input valid, input kind, input char_code, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/ptu_decode.sv
`default_nettype none

module ptu_decode import ptu_pkg::*; #(
  parameter int unsigned MaxChars = 256,
  localparam int unsigned CntW    = $clog2(MaxChars)
) (
  input  logic [DataW-1:0] data_byte_i,
  input  st_t              st_i,
  input  logic [CntW-1:0]  cnt_i,
  output st_t              st_o,
  output logic [CntW-1:0]  cnt_o,
  output dec_t             dec_o
);

  localparam logic [CntW-1:0] LastCnt = CntW'(MaxChars - 1);

  logic [2*DataW-1:0] window;
  logic [CodeW-1:0]   c1;
  logic [CodeW-1:0]   c2;
  logic [CntW-1:0]    cnt1;
  logic [CntW-1:0]    cnt2;

  always_comb begin
    window = {st_i.prev_byte, data_byte_i};
    c1     = CodeW'(window >> st_i.bit_phase);
    c2     = data_byte_i[CodeW-1:0];
    cnt1   = cnt_i + 1'b1;
    cnt2   = cnt1 + 1'b1;
    st_o   = st_i;
    cnt_o  = cnt_i;
    dec_o  = '0;
    if (!st_i.unpacking) begin
      dec_o.n = ResCntW'(1);
      unique case (data_byte_i)
        HdrStart: begin
          dec_o.n        = '0;
          st_o.unpacking = 1'b1;
          st_o.prev_byte = '0;
          st_o.bit_phase = PhaseFirst;
          cnt_o          = '0;
        end
        HdrIntro:  dec_o.res[0] = mk_rec_end(KIND_INTRO);
        HdrUncomp: dec_o.res[0] = mk_rec_end(KIND_UNCOMP);
        default:   dec_o.res[0] = mk_rec_end(KIND_UNKNOWN);
      endcase
    end else begin
      st_o.prev_byte = data_byte_i;
      dec_o.n        = ResCntW'(1);
      if (c1 == CodeEnd) begin
        dec_o.res[0]   = mk_rec_end(KIND_END);
        st_o.unpacking = 1'b0;
      end else begin
        dec_o.res[0] = mk_char(c1);
        cnt_o        = cnt1;
        if (cnt1 >= LastCnt) begin
          // length limit reached
          dec_o.n        = ResCntW'(2);
          dec_o.res[1]   = mk_rec_end(KIND_END);
          st_o.unpacking = 1'b0;
        end else if (st_i.bit_phase == PhaseWrap) begin
          dec_o.n = ResCntW'(2);
          if (c2 == CodeEnd) begin
            dec_o.res[1]   = mk_rec_end(KIND_END);
            st_o.unpacking = 1'b0;
          end else begin
            dec_o.res[1] = mk_char(c2);
            cnt_o        = cnt2;
            if (cnt2 >= LastCnt) begin
              dec_o.n        = ResCntW'(3);
              dec_o.res[2]   = mk_rec_end(KIND_END);
              st_o.unpacking = 1'b0;
            end else begin
              st_o.bit_phase = PhaseFirst;
            end
          end
        end else begin
          st_o.bit_phase = st_i.bit_phase + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ptu_res_fifo.sv
`default_nettype none

module ptu_res_fifo import ptu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dec_t     dec_i,
  input  logic     pop_i,
  output res_t     head_o,
  output fifo_st_t st_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] RoomCnt = CntW'(FifoDepth - MaxRes);

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] push_cnt;

  always_comb begin
    push_cnt = push_i ? CntW'(dec_i.n) : '0;
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + push_cnt - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (push_i && ResCntW'(i) < dec_i.n) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= dec_i.res[i];
      end
    end
  end

  assign head_o   = mem_q[rd_ptr_q];
  assign st_o.valid = (cnt_q != '0);
  // room for a full set of results after this cycle's transfer out
  assign st_o.room  = (cnt_q <= RoomCnt) || (pop_i && cnt_q == RoomCnt + 1'b1);

endmodule

`default_nettype wire

FILE: sv/packed_text_unpacker_unit.sv
// packed text unpacker: header classification and 7-bit msb-first text decode
// results of a byte are registered in the result queue and leave from its head
// throughput: one byte per cycle while each byte yields at most one result
// and the output is ready; a byte with two or three results can stall input until
// the four-entry result queue, which drains one result per ready cycle, has room
// reset: asynchronous active low, clears decode state and empties the queue
`default_nettype none

`include "packed_text_unpacker_unit_defines.svh"

module packed_text_unpacker_unit import ptu_pkg::*; #(
  parameter int unsigned MAX_CHARS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ptu_in_if.sink           in_i,
  ptu_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS);

  st_t             st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  dec_t            dec;
  res_t            head;
  fifo_st_t        fifo_st;
  logic            in_xfer;
  logic            out_xfer;
  logic            hdr_xfer;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign hdr_xfer = in_xfer && !st_q.unpacking;

  ptu_decode #(
    .MaxChars (MAX_CHARS)
  ) u_decode (
    .data_byte_i (in_i.data_byte),
    .st_i        (st_q),
    .cnt_i       (cnt_q),
    .st_o        (st_d),
    .cnt_o       (cnt_d),
    .dec_o       (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.unpacking <= 1'b0;
      st_q.prev_byte <= '0;
      st_q.bit_phase <= PhaseFirst;
      cnt_q          <= '0;
    end else if (in_xfer) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  ptu_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_xfer),
    .dec_i  (dec),
    .pop_i  (out_xfer),
    .head_o (head),
    .st_o   (fifo_st)
  );

  assign in_i.ready      = fifo_st.room;
  assign out_o.valid     = fifo_st.valid;
  assign out_o.kind      = head.kind;
  assign out_o.char_code = head.char_code;
  assign out_o.last      = head.last;

  `PTU_ASSERT_NEVER(a_phase_nonzero, st_q.bit_phase == '0)
  `PTU_ASSERT(a_hdr_idle, hdr_xfer |=> st_q.unpacking == $past(in_i.data_byte == HdrStart))
  `PTU_ASSERT(a_hdr_reported, hdr_xfer && in_i.data_byte != HdrStart |=> out_o.valid)
  `PTU_ASSERT(a_text_not_last, out_o.valid && out_o.kind == KIND_CHAR |-> !out_o.last)

endmodule

`default_nettype wire

FILE: bench/packed_text_unpacker_unit_tb.sv
`default_nettype none

module packed_text_unpacker_unit_tb;
  import ptu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxChars   = 256;
  localparam int          ByteTarget = 370;

  logic clk_i;
  logic rst_ni;

  ptu_in_if  in_if ();
  ptu_out_if out_if ();

  packed_text_unpacker_unit #(
    .MAX_CHARS(MaxChars)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [7:0] byte_stream[$];
  logic [6:0] text_codes[$];
  res_t       expected_results[$];

  // decoder state as the block should hold it
  logic        dec_unpacking = 1'b0;
  logic [7:0]  dec_prev      = '0;
  logic [2:0]  dec_phase     = PhaseFirst;
  logic [11:0] dec_count     = '0;

  int total_bytes  = 0;
  int bytes_in     = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int text_records = 0;
  bit taken        = 1'b0;
  bit rx_hold      = 1'b0;
  bit drain_done   = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic res_t make_result(input kind_e k, input logic [6:0] c);
    res_t r;
    r.kind      = k;
    r.char_code = c;
    r.last      = (k != KIND_CHAR);
    return r;
  endfunction

  function automatic bit take_code(input logic [15:0] window, input logic [2:0] shift);
    logic [6:0] c;
    c = 7'(window >> shift);
    if (c == CodeEnd) begin
      expected_results.push_back(make_result(KIND_END, '0));
      dec_unpacking = 1'b0;
      return 1'b1;
    end
    if (c < CodeSpace || c > CodeMaxPr) c = CodeSpace;
    expected_results.push_back(make_result(KIND_CHAR, c));
    dec_count = dec_count + 12'd1;
    if (dec_count >= 12'(MaxChars - 1)) begin
      expected_results.push_back(make_result(KIND_END, '0));
      dec_unpacking = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [15:0] window;
    logic [2:0]  phase;
    if (!dec_unpacking) begin
      if (b == HdrStart) begin
        dec_unpacking = 1'b1;
        dec_prev      = '0;
        dec_phase     = PhaseFirst;
        dec_count     = '0;
      end else if (b == HdrIntro) begin
        expected_results.push_back(make_result(KIND_INTRO, '0));
      end else if (b == HdrUncomp) begin
        expected_results.push_back(make_result(KIND_UNCOMP, '0));
      end else begin
        expected_results.push_back(make_result(KIND_UNKNOWN, '0));
      end
    end else begin
      window   = {dec_prev, b};
      phase    = dec_phase;
      dec_prev = b;
      if (!take_code(window, phase)) begin
        if (phase == PhaseWrap) begin
          if (!take_code(window, 3'd0)) dec_phase = PhaseFirst;
        end else begin
          dec_phase = phase + 3'd1;
        end
      end
    end
  endfunction

  // packs text_codes msb-first, 8 codes per 7 bytes, up to the byte holding the last code
  task automatic pack_text();
    int last_i;
    int n_bytes;
    int sent;
    logic [55:0] word;
    last_i  = text_codes.size() - 1;
    n_bytes = (last_i / 8) * 7 + ((last_i % 8) < 6 ? last_i % 8 : 6) + 1;
    byte_stream.push_back(HdrStart);
    while (text_codes.size() % 8 != 0) text_codes.push_back(7'($urandom));
    sent = 0;
    for (int g = 0; g < text_codes.size() / 8; g++) begin
      word = '0;
      for (int j = 0; j < 8; j++) word = {word[48:0], text_codes[8*g+j]};
      for (int k = 0; k < 7; k++) begin
        if (sent < n_bytes) begin
          byte_stream.push_back(word[55-8*k -: 8]);
          sent++;
        end
      end
    end
    text_codes.delete();
    text_records++;
  endtask

  task automatic random_text(input int n_codes, input bit terminated);
    logic [6:0] c;
    for (int i = 0; i < n_codes; i++) begin
      do c = 7'($urandom_range(0, 127)); while (c == CodeEnd);
      text_codes.push_back(c);
    end
    if (terminated) text_codes.push_back(CodeEnd);
    pack_text();
  endtask

  // idle phases: none, sender, receiver, both
  function automatic int idle_pct(input bit rx_side);
    int stage;
    stage = (total_bytes == 0) ? 0 : bytes_in * 4 / total_bytes;
    case (stage)
      1: return rx_side ? 0 : 52;
      2: return rx_side ? 52 : 0;
      3: return 11;
      default: return 0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // input side
  always @(posedge clk_i) begin
    taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      decode_byte(in_if.data_byte);
      void'(byte_stream.pop_front());
      bytes_in++;
    end
  end

  always @(negedge clk_i) begin
    if (total_bytes != 0 && bytes_in >= total_bytes / 3 && expected_results.size() == 0)
      drain_done = 1'b1;
    if (rst_ni && (!in_if.valid || taken)) begin
      if (byte_stream.size() != 0 && !(bytes_in >= total_bytes / 3 && !drain_done) &&
          $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= byte_stream[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d code=%h last=%b",
                                out_if.kind, out_if.char_code, out_if.last));
      end else begin
        want = expected_results.pop_front();
        if (out_if.kind !== want.kind || out_if.char_code !== want.char_code ||
            out_if.last !== want.last)
          flag_mismatch($sformatf(
              "result %0d: expected kind=%0d code=%h last=%b, got kind=%0d code=%h last=%b",
              results_seen, want.kind, want.char_code, want.last,
              out_if.kind, out_if.char_code, out_if.last));
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && !rx_hold && ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  // long receiver hold-off so the result queue fills and the input backs up
  initial begin
    wait (total_bytes != 0 && bytes_in >= total_bytes * 5 / 8);
    rx_hold = 1'b1;
    repeat (80) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d bytes in, %0d results pending", bytes_in, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    bit long_done;
    int pick;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    long_done       = 1'b0;

    // headers, then boundary codes, terminator on the first code of a wrapping byte
    byte_stream.push_back(HdrIntro);
    byte_stream.push_back(HdrUncomp);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    text_codes = {7'h7E, 7'h20, 7'h1F, 7'h7F, 7'h00, 7'h41, CodeEnd};
    pack_text();
    random_text(6, 1'b1);

    while (byte_stream.size() < ByteTarget) begin
      if (!long_done && byte_stream.size() > 120) begin
        random_text(MaxChars - 1, 1'b0);
        long_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) random_text($urandom_range(0, 24), 1'b1);
        else if (pick < 65) random_text($urandom_range(1, 12), 1'b0);
        else if (pick < 80) byte_stream.push_back(pick[0] ? HdrIntro : HdrUncomp);
        else byte_stream.push_back(8'($urandom));
      end
    end
    total_bytes = byte_stream.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_stream.size() != 0 || in_if.valid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("%0d bytes sent, %0d results checked, %0d text records",
             bytes_in, results_seen, text_records);
    $display("idle phases: none, sender, receiver, both; one record at the length limit");
    $display("one long output hold-off and one drain pause");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/ptu_pkg.sv
sv/ptu_in_if.sv
sv/ptu_out_if.sv
sv/ptu_decode.sv
sv/ptu_res_fifo.sv
sv/packed_text_unpacker_unit.sv
bench/packed_text_unpacker_unit_tb.sv
